### hw/rtl/tcp_pseudo_header_checksum_core_macros.svh
// Assertion macros shared by the checksum core checkers.
`ifndef TCP_PSEUDO_HEADER_CHECKSUM_CORE_MACROS_SVH
`define TCP_PSEUDO_HEADER_CHECKSUM_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define TCPCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define TCPCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/tcpcs_pkg.sv
// Types, constants and codes of the TCP pseudo-header checksum core.
package tcpcs_pkg;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned BC_W   = 2;

	localparam logic [WORD_W-1:0] PSEUDO_PROTOCOL = 16'h0006;
	localparam logic [WORD_W-1:0] LENGTH_MAX      = 16'hffff;

	// Byte count codes of one request word.
	localparam logic [BC_W-1:0] BC_NONE     = 2'd0;
	localparam logic [BC_W-1:0] BC_HIGH     = 2'd1;
	localparam logic [BC_W-1:0] BC_FULL     = 2'd2;
	localparam logic [BC_W-1:0] BC_FULL_ALT = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0] data_word;
		logic [BC_W-1:0]   byte_count;
		logic              last;
		logic [ADDR_W-1:0] src_addr;
		logic [ADDR_W-1:0] dst_addr;
	} tcpcs_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] checksum_value;
		logic [WORD_W-1:0] segment_length;
		logic              length_overflow;
	} tcpcs_out_t;

	// Control from the handshake stage to the accumulator.
	typedef struct packed {
		logic step;
		logic last;
	} tcpcs_ctl_t;

endpackage

### hw/rtl/tcp_pseudo_header_checksum_core.sv
// A last request passes the input stage and the result register before its result shows.
// Throughput: one request per cycle, set by the single accumulator add, except that
// a last request waits in the input stage only while the result register is full and stalled.
// Reset (arst_n low) clears the stage valid bits, the result valid and the running sum,
// byte count and overflow flag; payload registers are not reset.
// Non-last requests never produce a result.
module tcp_pseudo_header_checksum_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tcpcs_pkg::tcpcs_in_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tcpcs_pkg::tcpcs_out_t out_data
);
	import tcpcs_pkg::*;

	// Input stage: one accepted request, held until the accumulator takes it.
	logic       valid_s1;
	tcpcs_in_t  item_s1;

	// Result register, which parts the accumulator from the output handshake.
	logic       out_valid_q;
	tcpcs_out_t out_data_q;

	logic       advance;
	tcpcs_ctl_t ctl;
	tcpcs_out_t res;

	// A non-last request only updates state and can always move on. A last request
	// needs the result register free, or freed by the consumer in this cycle.
	assign advance  = valid_s1 && (!item_s1.last || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign ctl.step = advance;
	assign ctl.last = item_s1.last;

	tcpcs_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance && item_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers need no reset; their valid bits qualify them.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (advance && item_s1.last) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### hw/rtl/tcpcs_accum.sv
// Running ones'-complement sum, byte counter and pseudo-header finish.
module tcpcs_accum (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tcpcs_pkg::tcpcs_ctl_t  ctl,
	input  tcpcs_pkg::tcpcs_in_t   item,
	output tcpcs_pkg::tcpcs_out_t  res
);
	import tcpcs_pkg::*;

	logic [WORD_W-1:0] sum_q;
	logic [WORD_W-1:0] bytes_q;
	logic              ovf_q;

	logic [1:0]        n_bytes;
	logic [WORD_W-1:0] word_m;
	logic [WORD_W:0]   add_raw;
	logic [WORD_W:0]   add_fold;
	logic [WORD_W-1:0] sum_nxt;
	logic [WORD_W:0]   total;
	logic [WORD_W-1:0] bytes_nxt;
	logic              ovf_nxt;
	logic [WORD_W+2:0] wide;
	logic [WORD_W:0]   fold1;
	logic [WORD_W:0]   fold2;

	always_comb begin
		case (item.byte_count) inside
			BC_NONE:              n_bytes = 2'd0;
			BC_HIGH:              n_bytes = 2'd1;
			BC_FULL, BC_FULL_ALT: n_bytes = 2'd2;
			default:              n_bytes = 2'd0;
		endcase
	end

	// A lone byte is padded with a zero low byte.
	assign word_m = (n_bytes == 2'd1) ? {item.data_word[15:8], 8'h00} : item.data_word;

	assign add_raw  = {1'b0, sum_q} + {1'b0, word_m};
	assign add_fold = {1'b0, add_raw[WORD_W-1:0]} + {{WORD_W{1'b0}}, add_raw[WORD_W]};
	assign total    = {1'b0, bytes_q} + {{(WORD_W-1){1'b0}}, n_bytes};

	always_comb begin
		if (n_bytes == 2'd0) begin
			sum_nxt   = sum_q;
			bytes_nxt = bytes_q;
			ovf_nxt   = ovf_q;
		end else begin
			sum_nxt = add_fold[WORD_W-1:0];
			if (total[WORD_W]) begin
				bytes_nxt = LENGTH_MAX;
				ovf_nxt   = 1'b1;
			end else begin
				bytes_nxt = total[WORD_W-1:0];
				ovf_nxt   = ovf_q;
			end
		end
	end

	// Seven 16-bit terms fit in 19 bits; two end-around folds bring it back to 16.
	assign wide = {3'b000, sum_nxt}
		+ {3'b000, item.src_addr[31:16]} + {3'b000, item.src_addr[15:0]}
		+ {3'b000, item.dst_addr[31:16]} + {3'b000, item.dst_addr[15:0]}
		+ {3'b000, PSEUDO_PROTOCOL} + {3'b000, bytes_nxt};
	assign fold1 = {1'b0, wide[WORD_W-1:0]} + {{(WORD_W-2){1'b0}}, wide[WORD_W+2:WORD_W]};
	assign fold2 = {1'b0, fold1[WORD_W-1:0]} + {{WORD_W{1'b0}}, fold1[WORD_W]};

	assign res.checksum_value  = ~fold2[WORD_W-1:0];
	assign res.segment_length  = bytes_nxt;
	assign res.length_overflow = ovf_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			bytes_q <= '0;
			ovf_q   <= 1'b0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				sum_q   <= '0;
				bytes_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				sum_q   <= sum_nxt;
				bytes_q <= bytes_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

endmodule

### hw/rtl/tcpcs_checker.sv
// Port-level checker for the checksum core and its bind to the top level.
`include "tcp_pseudo_header_checksum_core_macros.svh"

module tcpcs_port_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input tcpcs_pkg::tcpcs_in_t  in_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input tcpcs_pkg::tcpcs_out_t out_data
);
	import tcpcs_pkg::*;

	// A stalled result must hold.
	`TCPCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

	// A saturated count is reported as the maximum length.
	`TCPCS_ASSERT_NOW(a_ovf_len, out_valid && out_data.length_overflow, out_data.segment_length == LENGTH_MAX, "overflow without saturated length")

	// A new result comes from an accepted last request.
	`TCPCS_ASSERT_NOW(a_out_source, $rose(out_valid), $past(in_valid && in_ready && in_data.last, 2), "result without a last request")

	// The input only stalls behind a full result register that is not being taken.
	`TCPCS_ASSERT_NOW(a_ready_stall, !in_ready, out_valid && !out_ready, "input stalled without output back-pressure")

endmodule

bind tcp_pseudo_header_checksum_core tcpcs_port_checker u_tcpcs_checker (.*);

### tb/tcpcs_checker.sv
// Checker for the checksum core: folds each accepted request into a segment sum and compares results.
module tcpcs_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  tcpcs_pkg::tcpcs_in_t  in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  tcpcs_pkg::tcpcs_out_t out_data,
	output int unsigned           fail_count,
	output int unsigned           pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tcpcs_pkg::*;

	logic [WORD_W-1:0] seg_sum;
	logic [WORD_W-1:0] seg_bytes;
	logic              seg_overflow;
	tcpcs_out_t        checksum_fifo[$];
	tcpcs_out_t        want;

	// Ones' complement add with end-around carry.
	function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

	function automatic void fold_request(input tcpcs_in_t req);
		logic [BC_W-1:0]   bytes;
		logic [WORD_W-1:0] word;
		logic [WORD_W:0]   total;
		logic [WORD_W-1:0] sum;
		tcpcs_out_t        res;
		bytes = (req.byte_count == BC_FULL_ALT) ? BC_FULL : req.byte_count;
		if (bytes != BC_NONE) begin
			word = req.data_word;
			if (bytes == BC_HIGH)
				word[7:0] = 8'h00;
			seg_sum = ones_add(seg_sum, word);
			total = {1'b0, seg_bytes} + {{(WORD_W-1){1'b0}}, bytes};
			if (total > {1'b0, LENGTH_MAX}) begin
				seg_bytes = LENGTH_MAX;
				seg_overflow = 1'b1;
			end else begin
				seg_bytes = total[WORD_W-1:0];
			end
		end
		if (req.last) begin
			sum = ones_add(seg_sum, req.src_addr[31:16]);
			sum = ones_add(sum, req.src_addr[15:0]);
			sum = ones_add(sum, req.dst_addr[31:16]);
			sum = ones_add(sum, req.dst_addr[15:0]);
			sum = ones_add(sum, PSEUDO_PROTOCOL);
			sum = ones_add(sum, seg_bytes);
			res.checksum_value = ~sum;
			res.segment_length = seg_bytes;
			res.length_overflow = seg_overflow;
			checksum_fifo.push_back(res);
			seg_sum = '0;
			seg_bytes = '0;
			seg_overflow = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_sum = '0;
			seg_bytes = '0;
			seg_overflow = 1'b0;
			checksum_fifo.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (checksum_fifo.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: checksum %h length %h overflow %b",
							out_data.checksum_value, out_data.segment_length,
							out_data.length_overflow);
				end else begin
					want = checksum_fifo.pop_front();
					if (out_data.checksum_value !== want.checksum_value ||
						out_data.segment_length !== want.segment_length ||
						out_data.length_overflow !== want.length_overflow) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result mismatch: expected %h/%h/%b, got %h/%h/%b",
								want.checksum_value, want.segment_length,
								want.length_overflow, out_data.checksum_value,
								out_data.segment_length, out_data.length_overflow);
					end
				end
			end
			if (in_valid && in_ready)
				fold_request(in_data);
			pending = checksum_fifo.size();
		end
	end

endmodule

### tb/tb_tcp_pseudo_header_checksum_core.sv
// Testbench top for the TCP pseudo-header checksum core: stimulus, back-pressure and verdict.
module tb_tcp_pseudo_header_checksum_core;
	timeunit 1ns;
	timeprecision 1ps;
	import tcpcs_pkg::*;

	// The limit leaves ample margin over the slowest correct run, even with the
	// output hold-off and random idling on both sides.
	localparam int unsigned CYCLE_LIMIT     = 40_000;
	localparam int unsigned RANDOM_REQUESTS = 1250;
	localparam int unsigned HOLD_CYCLES     = 300;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	tcpcs_in_t  in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	tcpcs_out_t out_data;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycle_count   = 0;
	int unsigned requests_sent = 0;

	// Steady turns off idling on both sides; the hold-off lines drive the long
	// receiver stall.
	logic steady     = 1'b0;
	logic stall_go   = 1'b0;
	logic stall_hold = 1'b0;

	tcp_pseudo_header_checksum_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	tcpcs_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic tcpcs_in_t mk_request(input logic [WORD_W-1:0] word,
		input logic [BC_W-1:0] bc, input logic last, input logic [ADDR_W-1:0] src,
		input logic [ADDR_W-1:0] dst);
		tcpcs_in_t req;
		req.data_word = word;
		req.byte_count = bc;
		req.last = last;
		req.src_addr = src;
		req.dst_addr = dst;
		return req;
	endfunction

	// Offers one request and returns at the edge that accepts it. Before the
	// request the sender may drop valid for a random number of cycles; once
	// valid is up it stays up with the same payload until accepted.
	task automatic offer(input tcpcs_in_t req);
		while (!steady && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests_sent++;
	endtask

	// Main stimulus: directed segments, then random segments. Ends with the
	// verdict.
	initial begin
		int unsigned      base;
		int unsigned      len;
		int unsigned      pick;
		logic [BC_W-1:0]  bc;
		logic             is_last;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A single full word with every data and address bit set.
		offer(mk_request(16'hffff, BC_FULL, 1'b1, 32'hffff_ffff, 32'hffff_ffff));
		// An empty segment: zero byte count on the last request, all-zero fields.
		offer(mk_request(16'h0000, BC_NONE, 1'b1, 32'h0000_0000, 32'h0000_0000));
		// The header alone sums to all ones, so the checksum must come out as
		// zero and must not be replaced by all ones.
		offer(mk_request(16'h1234, BC_NONE, 1'b1, 32'h0000_fff9, 32'h0000_0000));
		// An odd byte in the middle of a segment, a byte count of three and an
		// ignored zero-count word.
		offer(mk_request(16'habcd, BC_HIGH, 1'b0, 32'h1111_1111, 32'h2222_2222));
		offer(mk_request(16'h1234, BC_FULL_ALT, 1'b0, 32'h3333_3333, 32'h4444_4444));
		offer(mk_request(16'h5a5a, BC_NONE, 1'b0, 32'h5555_5555, 32'h6666_6666));
		offer(mk_request(16'hffff, BC_FULL, 1'b1, 32'hc0a8_0001, 32'h0a00_0002));
		// A segment that ends on a single padded byte.
		offer(mk_request(16'h8001, BC_FULL, 1'b0, 32'h0, 32'h0));
		offer(mk_request(16'h7f7f, BC_HIGH, 1'b1, 32'h8000_0000, 32'h7fff_ffff));
		// A last request with a byte count of three.
		offer(mk_request(16'hfedc, BC_FULL_ALT, 1'b1, 32'h7fff_ffff, 32'h8000_0000));
		// Full-scale words, so the running sum carries out.
		offer(mk_request(16'hffff, BC_FULL, 1'b0, 32'h0, 32'h0));
		offer(mk_request(16'hffff, BC_FULL, 1'b0, 32'h0, 32'h0));
		offer(mk_request(16'hff00, BC_HIGH, 1'b1, 32'hffff_ffff, 32'hffff_ffff));
		// A zero-count word then an empty last word.
		offer(mk_request(16'hbeef, BC_NONE, 1'b0, 32'h0, 32'h0));
		offer(mk_request(16'h0000, BC_NONE, 1'b1, 32'h0a0b_0c0d, 32'h0e0f_1011));

		// Random segments, mostly short so results come often, some longer.
		// Inner words are mostly full; a few carry odd, zero or alternate
		// byte counts as noise.
		base = requests_sent;
		while (requests_sent - base < RANDOM_REQUESTS) begin
			pick = $urandom_range(99);
			if (pick < 80)
				len = $urandom_range(1, 6);
			else if (pick < 95)
				len = $urandom_range(7, 24);
			else
				len = $urandom_range(25, 64);
			for (int unsigned i = 0; i < len; i++) begin
				is_last = (i == len - 1);
				if ($urandom_range(99) < (is_last ? 50 : 90))
					bc = BC_FULL;
				else
					bc = BC_W'($urandom_range(3));
				offer(mk_request(16'($urandom), bc, is_last, $urandom, $urandom));
				// Start the receiver hold-off early in the random part, and
				// later run a stretch with no idling on either side.
				if (requests_sent - base == 150)
					stall_go <= 1'b1;
				if (requests_sent - base == 500)
					steady <= 1'b1;
				if (requests_sent - base == 800)
					steady <= 1'b0;
			end
		end
		in_valid <= 1'b0;

		// Let the last accept reach the checker, drain, then allow a few
		// cycles for any stray result.
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Receiver: random stalls, none during the steady stretch, and a solid
	// stall while the hold-off runs.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_hold)
				out_ready <= 1'b0;
			else if (steady)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= 26);
		end
	end

	// Long receiver hold-off, counted here. The sender keeps offering requests
	// so the result register fills and the core stops accepting.
	initial begin
		wait (stall_go);
		@(posedge clk);
		stall_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		stall_hold <= 1'b0;
	end

	// Watchdog on the total cycle count.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

endmodule

### tcp_pseudo_header_checksum_core.f
+incdir+hw/rtl
hw/rtl/tcpcs_pkg.sv
hw/rtl/tcpcs_accum.sv
hw/rtl/tcp_pseudo_header_checksum_core.sv
hw/rtl/tcpcs_checker.sv
tb/tcpcs_checker.sv
tb/tb_tcp_pseudo_header_checksum_core.sv
